[design/fcrc_pkg.sv]
// Package for the flag-framed CRC-16 encoder: beat types, framing constants, CRC table.
package fcrc_pkg;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  localparam int RunMax = 8;
  localparam int CntW   = $clog2(RunMax + 1);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       message_end;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
  } out_beat_t;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    logic [CntW-1:0]        count;
  } run_t;

  function automatic logic [15:0] crc_table(input logic [7:0] idx);
    logic [15:0] v;
    v = {idx, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

[design/fcrc_framer.sv]
// Framer: CRC fold, escaping and flag insertion; builds the run of line bytes for one beat.
module fcrc_framer
  import fcrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  in_beat_t beat,
  input  logic     commit,
  output run_t     run
);

  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic        inside_message;

  assign running_crc_next = crc_table(running_crc[15:8])
                          ^ {running_crc[7:0], 8'h00}
                          ^ {8'h00, beat.payload_byte};

  always_comb begin
    logic [CntW-1:0] n;
    logic [2:0][7:0] vals;
    logic [2:0]      use_val;
    run.bytes = '0;
    n = '0;
    vals    = {running_crc_next[15:8], running_crc_next[7:0], beat.payload_byte};
    use_val = {beat.message_end, beat.message_end, 1'b1};
    if (!inside_message) begin
      run.bytes[n[2:0]] = FlagByte;
      n = n + CntW'(1);
    end
    for (int k = 0; k < 3; k++) begin
      if (use_val[k]) begin
        if (vals[k] == EscByte || vals[k] == FlagByte) begin
          run.bytes[n[2:0]] = EscByte;
          n = n + CntW'(1);
          run.bytes[n[2:0]] = vals[k] ^ EscXor;
        end else begin
          run.bytes[n[2:0]] = vals[k];
        end
        n = n + CntW'(1);
      end
    end
    if (beat.message_end) begin
      run.bytes[n[2:0]] = FlagByte;
      n = n + CntW'(1);
    end
    run.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc    <= '0;
      inside_message <= 1'b0;
    end else if (commit) begin
      running_crc    <= beat.message_end ? 16'h0000 : running_crc_next;
      inside_message <= !beat.message_end;
    end
  end

endmodule

[design/fcrc_serializer.sv]
// Serializer: holds one run of line bytes and shifts it out one beat per cycle while line_ready is high.
module fcrc_serializer
  import fcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  run_t      run,
  input  logic      run_valid,
  output logic      load,
  output logic      line_valid,
  input  logic      line_ready,
  output out_beat_t line
);

  logic [RunMax-1:0][7:0] bytes;
  logic [CntW-1:0]        count;

  assign line_valid     = (count != '0);
  assign line.line_byte = bytes[0];
  assign line.run_last  = (count == CntW'(1));
  assign load = (count == '0) || (count == CntW'(1) && line_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= run_valid ? run.count : '0;
    end else if (line_ready) begin
      count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= run.bytes;
    end else if (line_ready) begin
      bytes <= {8'h00, bytes[RunMax-1:1]};
    end
  end

endmodule

[design/flag_framed_crc16_encoder.sv]
// Top level of the flag-framed CRC-16 encoder: input register, framer and serializer.
//
//   channel  | handshake                     | beat
//   ---------+-------------------------------+----------------------------------
//   payload  | payload_valid / payload_ready | payload_byte, message_end
//   line     | line_valid / line_ready       | line_byte, run_last
//
// A payload beat is registered, then framed combinationally into a run of 1 to 8
// line bytes that the serializer sends one per cycle while line_ready is high; the
// next run loads as the last byte of the current one is taken. A payload byte gives
// one line byte, plus an escape byte when escaped and the opening flag when it opens
// a message; the last byte adds 3 to 5 for the CRC and closing flag, up to 8 line
// bytes for a one-byte message. Reset clears the CRC and closes any message. A stall
// on line_ready holds the run and backs up into the payload register.
module flag_framed_crc16_encoder
  import fcrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      payload_valid,
  output logic      payload_ready,
  input  in_beat_t  payload,
  output logic      line_valid,
  input  logic      line_ready,
  output out_beat_t line
);

  logic     held_valid;
  in_beat_t held;
  run_t     run;
  logic     load;

  assign payload_ready = !held_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (payload_ready) begin
      held_valid <= payload_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (payload_ready && payload_valid) begin
      held <= payload;
    end
  end

  fcrc_framer u_framer (
    .clk    (clk),
    .rst    (rst),
    .beat   (held),
    .commit (held_valid && load),
    .run    (run)
  );

  fcrc_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .run        (run),
    .run_valid  (held_valid),
    .load       (load),
    .line_valid (line_valid),
    .line_ready (line_ready),
    .line       (line)
  );

endmodule

[tb/sv/flag_framed_crc16_encoder_test.sv]
// Testbench for the flag-framed CRC-16 encoder: directed table, random messages, scoreboard.
module flag_framed_crc16_encoder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import fcrc_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int HoldCycles    = 300;

  typedef logic [7:0] byte_q_t[$];

  // typed run: first line byte in the top byte of the word
  typedef struct packed {
    in_beat_t    beat;
    logic [3:0]  cnt;
    logic [63:0] run;
  } dir_row_t;

  localparam int DirN = 19;
  localparam dir_row_t DirRows [DirN] = '{
    '{'{8'h00, 1'b1}, 4'd5, 64'h7E00_0000_7E00_0000},
    '{'{8'hFF, 1'b1}, 4'd5, 64'h7EFF_FF00_7E00_0000},
    '{'{8'h7E, 1'b1}, 4'd7, 64'h7E7D_5E7D_5E00_7E00},
    '{'{8'h7D, 1'b1}, 4'd7, 64'h7E7D_5D7D_5D00_7E00},
    '{'{8'h5E, 1'b1}, 4'd5, 64'h7E5E_5E00_7E00_0000},
    '{'{8'h7E, 1'b0}, 4'd0, 64'h0},
    '{'{8'h7D, 1'b0}, 4'd0, 64'h0},
    '{'{8'h00, 1'b0}, 4'd0, 64'h0},
    '{'{8'hFF, 1'b0}, 4'd0, 64'h0},
    '{'{8'hAA, 1'b0}, 4'd0, 64'h0},
    '{'{8'h55, 1'b1}, 4'd0, 64'h0},
    '{'{8'h01, 1'b0}, 4'd0, 64'h0},
    '{'{8'h80, 1'b0}, 4'd0, 64'h0},
    '{'{8'h7E, 1'b0}, 4'd0, 64'h0},
    '{'{8'h7E, 1'b1}, 4'd0, 64'h0},
    '{'{8'hFF, 1'b0}, 4'd0, 64'h0},
    '{'{8'hFF, 1'b1}, 4'd0, 64'h0},
    '{'{8'h7D, 1'b0}, 4'd0, 64'h0},
    '{'{8'h5D, 1'b1}, 4'd0, 64'h0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      payload_valid;
  logic      payload_ready;
  in_beat_t  payload;
  logic      line_valid;
  logic      line_ready;
  out_beat_t line;

  out_beat_t pending_line[$];
  logic [15:0] crc_acc;
  logic        msg_open;
  int          mismatches;
  int          send_idle;
  int          stall_pct;
  int          msg_left;
  int          idle_cycles;
  logic        hold_req;

  flag_framed_crc16_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .payload_valid(payload_valid),
    .payload_ready(payload_ready),
    .payload      (payload),
    .line_valid   (line_valid),
    .line_ready   (line_ready),
    .line         (line)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc_fold_byte(logic [15:0] c, logic [7:0] d);
    logic [15:0] t;
    t = {c[15:8], 8'h00};
    for (int k = 0; k < 8; k++) begin
      t = t[15] ? ({t[14:0], 1'b0} ^ CrcPoly) : {t[14:0], 1'b0};
    end
    return t ^ {c[7:0], 8'h00} ^ {8'h00, d};
  endfunction

  function automatic byte_q_t stuffed(logic [7:0] v);
    byte_q_t r;
    if (v == EscByte || v == FlagByte) begin
      r.push_back(EscByte);
      r.push_back(v ^ EscXor);
    end else begin
      r.push_back(v);
    end
    return r;
  endfunction

  // frames one payload beat, advancing the CRC and message state
  function automatic byte_q_t frame_payload(in_beat_t b);
    byte_q_t r;
    if (!msg_open) begin
      r.push_back(FlagByte);
      msg_open = 1'b1;
    end
    crc_acc = crc_fold_byte(crc_acc, b.payload_byte);
    r = {r, stuffed(b.payload_byte)};
    if (b.message_end) begin
      r = {r, stuffed(crc_acc[7:0])};
      r = {r, stuffed(crc_acc[15:8])};
      r.push_back(FlagByte);
      crc_acc  = '0;
      msg_open = 1'b0;
    end
    return r;
  endfunction

  function automatic in_beat_t random_payload();
    in_beat_t b;
    if (msg_left == 0) begin
      msg_left = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(1, 5);
    end
    case ($urandom_range(7))
      0: b.payload_byte = EscByte;
      1: b.payload_byte = FlagByte;
      2: b.payload_byte = 8'h00;
      3: b.payload_byte = 8'hFF;
      default: b.payload_byte = 8'($urandom_range(255));
    endcase
    b.message_end = (msg_left == 1);
    msg_left--;
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b, input logic [3:0] cnt, input logic [63:0] typed);
    byte_q_t run;
    out_beat_t o;
    while ($urandom_range(99) < send_idle) begin
      payload_valid <= 1'b0;
      @(negedge clk);
    end
    payload_valid <= 1'b1;
    payload       <= b;
    @(posedge clk);
    while (!payload_ready) @(posedge clk);
    run = frame_payload(b);
    if (cnt != 0) begin
      run = {};
      for (int j = 0; j < cnt; j++) run.push_back(typed[63 - 8*j -: 8]);
    end
    foreach (run[j]) begin
      o.line_byte = run[j];
      o.run_last  = (j == run.size() - 1);
      pending_line.push_back(o);
    end
    @(negedge clk);
  endtask

  task automatic drain();
    payload_valid <= 1'b0;
    while (pending_line.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase(input int n, input int sidle, input int rstall);
    send_idle = sidle;
    stall_pct = rstall;
    repeat (n) send_beat(random_payload(), 4'd0, 64'h0);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    line_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        line_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      line_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && line_valid && line_ready) begin
      if (pending_line.size() == 0) begin
        $error("unexpected line beat: line_byte %h run_last %b", line.line_byte, line.run_last);
        mismatches++;
      end else begin
        want = pending_line.pop_front();
        if (line.line_byte !== want.line_byte) begin
          $error("line_byte: expected %h, got %h", want.line_byte, line.line_byte);
          mismatches++;
        end
        if (line.run_last !== want.run_last) begin
          $error("run_last: expected %b, got %b", want.run_last, line.run_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (payload_valid && payload_ready) || (line_valid && line_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[flag_framed_crc16_encoder] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst           = 1'b1;
    payload_valid = 1'b0;
    payload       = '0;
    crc_acc       = '0;
    msg_open      = 1'b0;
    mismatches    = 0;
    send_idle     = 0;
    stall_pct     = 0;
    msg_left      = 0;
    idle_cycles   = 0;
    hold_req      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int k = 0; k < DirN; k++) begin
      send_beat(DirRows[k].beat, DirRows[k].cnt, DirRows[k].run);
    end
    drain();

    // long receiver hold while the sender keeps pushing
    hold_req = 1'b1;
    random_phase(60, 0, 0);
    drain();
    random_phase(50, 84, 0);
    drain();
    random_phase(50, 0, 84);
    drain();
    random_phase(50, 11, 11);
    drain();

    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("[flag_framed_crc16_encoder] OK");
    end else begin
      $display("[flag_framed_crc16_encoder] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
design/fcrc_pkg.sv
design/fcrc_framer.sv
design/fcrc_serializer.sv
design/flag_framed_crc16_encoder.sv
tb/sv/flag_framed_crc16_encoder_test.sv
